// ===== hdl/ljss_pkg.sv =====
// Shared types and codes for the link job step sequencer.
`timescale 1ns / 1ps

package ljss_pkg;

  // Item kinds
  localparam logic [1:0] ITEM_LOAD  = 2'd0;
  localparam logic [1:0] ITEM_START = 2'd1;
  localparam logic [1:0] ITEM_POLL  = 2'd2;

  // Step kinds
  localparam logic [2:0] SK_WRITE = 3'd0;
  localparam logic [2:0] SK_READ  = 3'd1;
  localparam logic [2:0] SK_WAIT  = 3'd2;
  localparam logic [2:0] SK_CHECK = 3'd3;
  localparam logic [2:0] SK_QUERY = 3'd4;

  // Result events
  localparam logic [2:0] EV_ACCEPT = 3'd0;
  localparam logic [2:0] EV_WRITE  = 3'd1;
  localparam logic [2:0] EV_READ   = 3'd2;
  localparam logic [2:0] EV_REASON = 3'd3;
  localparam logic [2:0] EV_ABORT  = 3'd4;
  localparam logic [2:0] EV_DONE   = 3'd5;
  localparam logic [2:0] EV_REJECT = 3'd6;

  // Job error codes
  localparam logic [3:0] ERR_OK            = 4'd0;
  localparam logic [3:0] ERR_BUSY          = 4'd1;
  localparam logic [3:0] ERR_NOT_READY     = 4'd2;
  localparam logic [3:0] ERR_READY_TIMEOUT = 4'd3;
  localparam logic [3:0] ERR_DROPPED       = 4'd4;
  localparam logic [3:0] ERR_XFER          = 4'd5;
  localparam logic [3:0] ERR_XFER_TIMEOUT  = 4'd6;
  localparam logic [3:0] ERR_NACK          = 4'd7;
  localparam logic [3:0] ERR_NACK_CODE     = 4'd8;

  localparam logic [7:0]  REASON_OPCODE = 8'hA6;
  localparam logic [15:0] REASON_LEN    = 16'd1;

  // Configuration registers
  localparam int unsigned CFG_IDX_W       = 2;
  localparam logic [CFG_IDX_W-1:0] REG_BACKEND_WAIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_XFER_WAIT    = 2'd1;
  localparam logic [15:0] WAIT_LIMIT_RESET = 16'd100;

  typedef struct packed {
    logic [15:0] backend_wait_ms;
    logic [15:0] xfer_wait_ms;
  } cfg_regs_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  opcode;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] len;
  } step_entry_t;

  localparam int unsigned STEP_W = $bits(step_entry_t);

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  slot;
    logic [2:0]  step_kind;
    logic [7:0]  opcode;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] len;
    logic        tick;
    logic        ready_edge;
    logic        ready_level;
    logic        ack_level;
    logic [1:0]  link_state;
  } item_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [7:0]  opcode;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] len;
    logic [3:0]  err;
    logic [7:0]  nack_reason;
    logic        last;
  } result_t;

endpackage

// ===== hdl/link_job_step_sequencer_core.sv =====
// Top level of the link job step sequencer.
`timescale 1ns / 1ps
//
// Runs a job of up to STEP_SLOTS loaded steps against a peer device.
// Input channel: an item (load step, start job or poll) is taken when start
// is high and busy is low. Items are processed one at a time; busy stays high
// until the item's results have been issued.
// Result channel: each result word appears for one cycle with out_valid high;
// out_last marks the final word caused by an item. The receiver cannot stall.
// Order of work: a load gives its result from the dispatch state; a poll of a
// running job goes on to evaluate the current step, and every step that
// completes chains into the next one within the same poll, with the job done
// word following an abort; a start check reads each used step slot from the
// step RAM, one read per cycle. A poll that leaves the job waiting gives no
// result and frees busy. Configuration writes are always ready.
// Reset: the job is idle and the wait limits return to 100 ms; step slots
// hold nothing meaningful until loaded.

module link_job_step_sequencer_core
  import ljss_pkg::*;
#(
  parameter int unsigned STEP_SLOTS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           in_kind,
  input  logic [2:0]           in_slot,
  input  logic [2:0]           in_step_kind,
  input  logic [7:0]           in_opcode,
  input  logic [15:0]          in_x,
  input  logic [15:0]          in_y,
  input  logic [15:0]          in_len,
  input  logic                 in_tick,
  input  logic                 in_ready_edge,
  input  logic                 in_ready_level,
  input  logic                 in_ack_level,
  input  logic [1:0]           in_link_state,
  output logic                 out_valid,
  output logic [2:0]           out_event_res,
  output logic [7:0]           out_opcode_out,
  output logic [15:0]          out_x_out,
  output logic [15:0]          out_y_out,
  output logic [15:0]          out_len_out,
  output logic [3:0]           out_err,
  output logic [7:0]           out_nack_reason,
  output logic                 out_last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  localparam int unsigned AW = (STEP_SLOTS > 1) ? $clog2(STEP_SLOTS) : 1;

  item_t             item;
  cfg_regs_t         cfg_regs;
  result_t           res;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [AW-1:0]     mem_raddr;
  logic [STEP_W-1:0] mem_wdata;
  logic [STEP_W-1:0] mem_rdata;

  assign item.kind        = in_kind;
  assign item.slot        = in_slot;
  assign item.step_kind   = in_step_kind;
  assign item.opcode      = in_opcode;
  assign item.x           = in_x;
  assign item.y           = in_y;
  assign item.len         = in_len;
  assign item.tick        = in_tick;
  assign item.ready_edge  = in_ready_edge;
  assign item.ready_level = in_ready_level;
  assign item.ack_level   = in_ack_level;
  assign item.link_state  = in_link_state;

  ljss_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (cfg_regs)
  );

  ljss_ram #(
    .WIDTH (STEP_W),
    .DEPTH (STEP_SLOTS)
  ) u_step_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ljss_ctrl #(
    .STEP_SLOTS (STEP_SLOTS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (item),
    .cfg       (cfg_regs),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .res_valid (out_valid),
    .res       (res)
  );

  assign out_event_res   = res.event_res;
  assign out_opcode_out  = res.opcode;
  assign out_x_out       = res.x;
  assign out_y_out       = res.y;
  assign out_len_out     = res.len;
  assign out_err         = res.err;
  assign out_nack_reason = res.nack_reason;
  assign out_last        = res.last;

  // an abort word is always followed straight away by the job done word
  a_abort_then_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_res == EV_ABORT) |=> out_valid && (out_event_res == EV_DONE))
    else $error("abort not followed by job done");

  a_last_marking: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_event_res != EV_ABORT)))
    else $error("last flag wrong");

  a_reason_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_err != ERR_NACK_CODE) |-> (out_nack_reason == 8'd0))
    else $error("nack reason set without nack code");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

endmodule

// ===== hdl/ljss_ram.sv =====
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps

module ljss_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/ljss_cfg.sv =====
// Configuration register bank: wait limits.
`timescale 1ns / 1ps

module ljss_cfg
  import ljss_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  output cfg_regs_t            regs
);

  cfg_regs_t regs_r, regs_nxt;

  assign cfg_ready = 1'b1;
  assign regs      = regs_r;

  always_comb begin
    regs_nxt = regs_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_BACKEND_WAIT: regs_nxt.backend_wait_ms = cfg_data;
        REG_XFER_WAIT:    regs_nxt.xfer_wait_ms    = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.backend_wait_ms <= WAIT_LIMIT_RESET;
      regs_r.xfer_wait_ms    <= WAIT_LIMIT_RESET;
    end else begin
      regs_r <= regs_nxt;
    end
  end

endmodule

// ===== hdl/ljss_ctrl.sv =====
// Job sequencer: item dispatch, start scan and step evaluation around the step RAM.
`timescale 1ns / 1ps

module ljss_ctrl
  import ljss_pkg::*;
#(
  parameter int unsigned STEP_SLOTS = 8,
  localparam int unsigned AW = (STEP_SLOTS > 1) ? $clog2(STEP_SLOTS) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  item_t             in_item,
  input  cfg_regs_t         cfg,
  output logic              mem_we,
  output logic [AW-1:0]     mem_waddr,
  output logic [STEP_W-1:0] mem_wdata,
  output logic [AW-1:0]     mem_raddr,
  input  logic [STEP_W-1:0] mem_rdata,
  output logic              res_valid,
  output result_t           res
);

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_DISPATCH = 5'b00010,
    S_SCAN     = 5'b00100,
    S_EVAL     = 5'b01000,
    S_FIN      = 5'b10000
  } state_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_START = 2'd1,
    PH_BUSY  = 2'd2
  } phase_t;

  state_t      state_r, state_nxt;
  phase_t      phase_r, phase_nxt;
  item_t       item_r, item_nxt;
  logic [3:0]  step_count_r, step_count_nxt;
  logic [2:0]  step_pos_r, step_pos_nxt;
  logic [15:0] elapsed_r, elapsed_nxt;
  logic        ready_pend_r, ready_pend_nxt;
  logic        query_r, query_nxt;
  logic [2:0]  scan_idx_r, scan_idx_nxt;
  logic        scan_bad_r, scan_bad_nxt;
  logic [3:0]  fin_err_r, fin_err_nxt;
  logic        res_valid_r, res_valid_nxt;
  result_t     res_r, res_nxt;

  function automatic result_t mk_res(logic [2:0] ev, logic [3:0] err, logic [7:0] reason,
                                     logic last);
    result_t r;
    r             = '0;
    r.event_res   = ev;
    r.err         = err;
    r.nack_reason = reason;
    r.last        = last;
    return r;
  endfunction

  assign busy      = (state_r != S_IDLE);
  assign res_valid = res_valid_r;
  assign res       = res_r;

  always_comb begin
    step_entry_t step;
    step_entry_t load_entry;
    logic        bad_now;
    logic [3:0]  pos_inc;
    logic        done, lerr, rdy, ack;
    logic        do_next, do_finish, do_xfer, do_abort;
    logic [3:0]  f_err;
    logic [7:0]  f_reason;
    result_t     xfer_res;

    step       = step_entry_t'(mem_rdata);
    load_entry.kind   = item_r.step_kind;
    load_entry.opcode = item_r.opcode;
    load_entry.x      = item_r.x;
    load_entry.y      = item_r.y;
    load_entry.len    = item_r.len;
    bad_now    = (step.kind > SK_QUERY) ||
                 (((step.kind == SK_WRITE) || (step.kind == SK_READ)) &&
                  (step.len > item_r.len));
    pos_inc    = {1'b0, step_pos_r} + 4'd1;
    done       = item_r.link_state[0];
    lerr       = item_r.link_state[1];
    rdy        = item_r.ready_level;
    ack        = item_r.ack_level;
    do_next    = 1'b0;
    do_finish  = 1'b0;
    do_xfer    = 1'b0;
    do_abort   = 1'b0;
    f_err      = ERR_OK;
    f_reason   = 8'd0;
    xfer_res   = '0;

    state_nxt      = state_r;
    phase_nxt      = phase_r;
    item_nxt       = item_r;
    step_count_nxt = step_count_r;
    step_pos_nxt   = step_pos_r;
    elapsed_nxt    = elapsed_r;
    ready_pend_nxt = ready_pend_r;
    query_nxt      = query_r;
    scan_idx_nxt   = scan_idx_r;
    scan_bad_nxt   = scan_bad_r;
    fin_err_nxt    = fin_err_r;
    res_valid_nxt  = 1'b0;
    res_nxt        = res_r;

    mem_we    = 1'b0;
    mem_waddr = AW'(item_r.slot);
    mem_wdata = load_entry;
    mem_raddr = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          item_nxt  = in_item;
          state_nxt = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        state_nxt = S_IDLE;
        case (item_r.kind)
          ITEM_LOAD: begin
            res_valid_nxt = 1'b1;
            if (phase_r != PH_IDLE) begin
              res_nxt = mk_res(EV_REJECT, ERR_BUSY, 8'd0, 1'b1);
            end else if (int'(item_r.slot) >= STEP_SLOTS) begin
              res_nxt = mk_res(EV_REJECT, ERR_OK, 8'd0, 1'b1);
            end else begin
              mem_we  = 1'b1;
              res_nxt = mk_res(EV_ACCEPT, ERR_OK, 8'd0, 1'b1);
            end
          end
          ITEM_START: begin
            if (phase_r != PH_IDLE) begin
              res_valid_nxt = 1'b1;
              res_nxt       = mk_res(EV_REJECT, ERR_BUSY, 8'd0, 1'b1);
            end else if (int'(item_r.slot) + 1 > STEP_SLOTS) begin
              res_valid_nxt = 1'b1;
              res_nxt       = mk_res(EV_REJECT, ERR_OK, 8'd0, 1'b1);
            end else begin
              scan_idx_nxt = 3'd0;
              scan_bad_nxt = 1'b0;
              mem_raddr    = '0;
              state_nxt    = S_SCAN;
            end
          end
          ITEM_POLL: begin
            if (item_r.ready_edge) begin
              ready_pend_nxt = 1'b1;
            end
            if (item_r.tick && (elapsed_r != 16'hFFFF)) begin
              elapsed_nxt = elapsed_r + 16'd1;
            end
            if (phase_r != PH_IDLE) begin
              mem_raddr = AW'(step_pos_r);
              state_nxt = S_EVAL;
            end
          end
          default: ;
        endcase
      end

      S_SCAN: begin
        if (scan_idx_r == item_r.slot) begin
          state_nxt     = S_IDLE;
          res_valid_nxt = 1'b1;
          if (bad_now || scan_bad_r) begin
            res_nxt = mk_res(EV_REJECT, ERR_OK, 8'd0, 1'b1);
          end else begin
            step_count_nxt = {1'b0, item_r.slot} + 4'd1;
            step_pos_nxt   = 3'd0;
            elapsed_nxt    = 16'd0;
            ready_pend_nxt = 1'b0;
            query_nxt      = 1'b0;
            phase_nxt      = PH_START;
            res_nxt        = mk_res(EV_ACCEPT, ERR_OK, 8'd0, 1'b1);
          end
        end else begin
          scan_bad_nxt = scan_bad_r | bad_now;
          scan_idx_nxt = scan_idx_r + 3'd1;
          mem_raddr    = AW'(scan_idx_r + 3'd1);
        end
      end

      S_EVAL: begin
        state_nxt = S_IDLE;
        if (phase_r == PH_START) begin
          if ((step.kind != SK_WRITE) && (step.kind != SK_READ)) begin
            if (ready_pend_r) begin
              if (step.kind == SK_WAIT) begin
                do_next = 1'b1;
              end else if (!rdy) begin
                do_finish = 1'b1;
                f_err     = ERR_DROPPED;
              end else if (ack) begin
                do_next = 1'b1;
              end else if ((step.kind == SK_CHECK) || !done) begin
                do_finish = 1'b1;
                f_err     = ERR_NACK;
              end else begin
                query_nxt          = 1'b1;
                do_xfer            = 1'b1;
                xfer_res.event_res = EV_REASON;
                xfer_res.opcode    = REASON_OPCODE;
                xfer_res.len       = REASON_LEN;
              end
            end else if (elapsed_r >= step.len) begin
              do_finish = 1'b1;
              f_err     = ERR_READY_TIMEOUT;
            end
          end else if (!done || !rdy) begin
            if (elapsed_r >= cfg.backend_wait_ms) begin
              do_finish = 1'b1;
              f_err     = !done ? ERR_BUSY : ERR_NOT_READY;
            end
          end else begin
            do_xfer            = 1'b1;
            xfer_res.event_res = (step.kind == SK_WRITE) ? EV_WRITE : EV_READ;
            xfer_res.opcode    = step.opcode;
            xfer_res.x         = step.x;
            xfer_res.y         = step.y;
            xfer_res.len       = step.len;
          end
        end else begin
          if (done) begin
            if (query_r) begin
              do_finish = 1'b1;
              f_err     = !lerr ? ERR_NACK_CODE : ERR_NACK;
              f_reason  = !lerr ? item_r.opcode : 8'd0;
            end else if (!lerr) begin
              do_next = 1'b1;
            end else begin
              do_finish = 1'b1;
              f_err     = ERR_XFER;
            end
          end else if (elapsed_r >= cfg.xfer_wait_ms) begin
            do_abort = 1'b1;
          end
        end

        // a completed step either closes the job or chains into the next slot
        if (do_next) begin
          if (pos_inc >= step_count_r) begin
            do_finish = 1'b1;
            f_err     = ERR_OK;
          end else begin
            phase_nxt    = PH_START;
            elapsed_nxt  = 16'd0;
            step_pos_nxt = pos_inc[2:0];
            mem_raddr    = AW'(pos_inc[2:0]);
            state_nxt    = S_EVAL;
          end
        end

        if (do_xfer) begin
          ready_pend_nxt = 1'b0;
          phase_nxt      = PH_BUSY;
          elapsed_nxt    = 16'd0;
          xfer_res.last  = 1'b1;
          res_valid_nxt  = 1'b1;
          res_nxt        = xfer_res;
        end

        if (do_finish) begin
          phase_nxt     = PH_IDLE;
          query_nxt     = 1'b0;
          res_valid_nxt = 1'b1;
          res_nxt       = mk_res(EV_DONE, f_err, f_reason, 1'b1);
        end

        if (do_abort) begin
          phase_nxt     = PH_IDLE;
          query_nxt     = 1'b0;
          fin_err_nxt   = query_r ? ERR_NACK : ERR_XFER_TIMEOUT;
          res_valid_nxt = 1'b1;
          res_nxt       = mk_res(EV_ABORT, ERR_OK, 8'd0, 1'b0);
          state_nxt     = S_FIN;
        end
      end

      S_FIN: begin
        res_valid_nxt = 1'b1;
        res_nxt       = mk_res(EV_DONE, fin_err_r, 8'd0, 1'b1);
        state_nxt     = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      phase_r      <= PH_IDLE;
      step_count_r <= 4'd0;
      step_pos_r   <= 3'd0;
      elapsed_r    <= 16'd0;
      ready_pend_r <= 1'b0;
      query_r      <= 1'b0;
      scan_idx_r   <= 3'd0;
      scan_bad_r   <= 1'b0;
      fin_err_r    <= ERR_OK;
      res_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      step_count_r <= step_count_nxt;
      step_pos_r   <= step_pos_nxt;
      elapsed_r    <= elapsed_nxt;
      ready_pend_r <= ready_pend_nxt;
      query_r      <= query_nxt;
      scan_idx_r   <= scan_idx_nxt;
      scan_bad_r   <= scan_bad_nxt;
      fin_err_r    <= fin_err_nxt;
      res_valid_r  <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    res_r  <= res_nxt;
  end

endmodule

// ===== tb/sv/tb_link_job_step_sequencer_core.sv =====
// Self-checking testbench for the link job step sequencer core.
`timescale 1ns / 1ps

module tb_link_job_step_sequencer_core
  import ljss_pkg::*;
();

  localparam int          SLOT_COUNT  = 8;
  localparam int          MAX_WORDS   = 3;
  localparam int          QUIET_CYC   = 16;
  localparam int          CYCLE_LIMIT = 200000;
  localparam int          PHASES      = 8;
  localparam int          PHASE_ITEMS = 46;
  localparam logic [1:0]  ITEM_UNUSED = 2'd3;
  localparam logic [2:0]  SK_BAD      = 3'd7;

  typedef enum logic [1:0] {SEQ_IDLE, SEQ_ARMED, SEQ_XFER} seq_phase_t;

  typedef struct {
    logic [CFG_IDX_W-1:0] idx;
    logic [15:0]          data;
  } cfg_write_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0]  in_kind = '0;
  logic [2:0]  in_slot = '0;
  logic [2:0]  in_step_kind = '0;
  logic [7:0]  in_opcode = '0;
  logic [15:0] in_x = '0;
  logic [15:0] in_y = '0;
  logic [15:0] in_len = '0;
  logic        in_tick = 1'b0;
  logic        in_ready_edge = 1'b0;
  logic        in_ready_level = 1'b0;
  logic        in_ack_level = 1'b0;
  logic [1:0]  in_link_state = '0;
  logic        out_valid;
  logic [2:0]  out_event_res;
  logic [7:0]  out_opcode_out;
  logic [15:0] out_x_out;
  logic [15:0] out_y_out;
  logic [15:0] out_len_out;
  logic [3:0]  out_err;
  logic [7:0]  out_nack_reason;
  logic        out_last;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]          cfg_data = '0;

  link_job_step_sequencer_core #(.STEP_SLOTS(SLOT_COUNT)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind), .in_slot(in_slot), .in_step_kind(in_step_kind),
    .in_opcode(in_opcode), .in_x(in_x), .in_y(in_y), .in_len(in_len),
    .in_tick(in_tick), .in_ready_edge(in_ready_edge),
    .in_ready_level(in_ready_level), .in_ack_level(in_ack_level),
    .in_link_state(in_link_state),
    .out_valid(out_valid), .out_event_res(out_event_res),
    .out_opcode_out(out_opcode_out), .out_x_out(out_x_out), .out_y_out(out_y_out),
    .out_len_out(out_len_out), .out_err(out_err), .out_nack_reason(out_nack_reason),
    .out_last(out_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Sequencer state as the testbench sees it
  seq_phase_t  seq_phase = SEQ_IDLE;
  step_entry_t slots [SLOT_COUNT];
  logic [3:0]  job_len = '0;
  logic [3:0]  cur_step = '0;
  logic [15:0] wait_ms = '0;
  logic        edge_held = 1'b0;
  logic        reason_pending = 1'b0;
  logic [15:0] lim_backend = WAIT_LIMIT_RESET;
  logic [15:0] lim_xfer = WAIT_LIMIT_RESET;

  result_t    burst [$];
  result_t    due_words [$];
  item_t      pending_items [$];
  cfg_write_t cfg_writes [$];
  item_t      cur_item;
  int         gap_left = 0;
  bit         steady_run = 1'b0;
  int         queued_items = 0;
  int         fail_count = 0;
  int         cycle_count = 0;

  task automatic post_word(input logic [2:0] ev, input logic [7:0] op,
                           input logic [15:0] x, input logic [15:0] y,
                           input logic [15:0] len, input logic [3:0] err,
                           input logic [7:0] reason);
    result_t w;
    if (burst.size() < MAX_WORDS) begin
      w.event_res = ev;
      w.opcode = op;
      w.x = x;
      w.y = y;
      w.len = len;
      w.err = err;
      w.nack_reason = reason;
      w.last = 1'b0;
      burst.push_back(w);
    end
  endtask

  task automatic end_job(input logic [3:0] err, input logic [7:0] reason);
    seq_phase = SEQ_IDLE;
    reason_pending = 1'b0;
    post_word(EV_DONE, '0, '0, '0, '0, err, (err == ERR_NACK_CODE) ? reason : 8'h00);
  endtask

  task automatic next_slot();
    cur_step++;
    if (cur_step >= job_len) begin
      end_job(ERR_OK, 8'h00);
    end else begin
      seq_phase = SEQ_ARMED;
      wait_ms = '0;
    end
  endtask

  task automatic begin_xfer(input logic [2:0] ev, input logic [7:0] op,
                            input logic [15:0] x, input logic [15:0] y,
                            input logic [15:0] len);
    edge_held = 1'b0;
    seq_phase = SEQ_XFER;
    wait_ms = '0;
    post_word(ev, op, x, y, len, ERR_OK, 8'h00);
  endtask

  // Works out the words one accepted item gives and queues them
  task automatic advance_sequencer(input item_t it);
    step_entry_t cur;
    logic [3:0]  prev, n;
    logic        ok, was_query, rdy, ack, done, lerr;
    rdy  = it.ready_level;
    ack  = it.ack_level;
    done = it.link_state[0];
    lerr = it.link_state[1];
    case (it.kind)
      ITEM_LOAD: begin
        if (seq_phase != SEQ_IDLE) begin
          post_word(EV_REJECT, '0, '0, '0, '0, ERR_BUSY, 8'h00);
        end else begin
          slots[it.slot] = '{kind: it.step_kind, opcode: it.opcode, x: it.x, y: it.y,
                             len: it.len};
          post_word(EV_ACCEPT, '0, '0, '0, '0, ERR_OK, 8'h00);
        end
      end
      ITEM_START: begin
        n = {1'b0, it.slot} + 4'd1;
        if (seq_phase != SEQ_IDLE) begin
          post_word(EV_REJECT, '0, '0, '0, '0, ERR_BUSY, 8'h00);
        end else begin
          ok = 1'b1;
          for (int i = 0; i < n; i++) begin
            if (slots[i].kind > SK_QUERY) ok = 1'b0;
            if ((slots[i].kind == SK_WRITE || slots[i].kind == SK_READ) &&
                slots[i].len > it.len) ok = 1'b0;
          end
          if (!ok) begin
            post_word(EV_REJECT, '0, '0, '0, '0, ERR_OK, 8'h00);
          end else begin
            job_len = n;
            cur_step = '0;
            wait_ms = '0;
            edge_held = 1'b0;
            reason_pending = 1'b0;
            seq_phase = SEQ_ARMED;
            post_word(EV_ACCEPT, '0, '0, '0, '0, ERR_OK, 8'h00);
          end
        end
      end
      ITEM_POLL: begin
        if (it.ready_edge) edge_held = 1'b1;
        if (it.tick && wait_ms != 16'hFFFF) wait_ms++;
        // steps may chain within one poll until the job waits or ends or a transfer starts
        while (seq_phase != SEQ_IDLE) begin
          prev = cur_step;
          cur = slots[cur_step[2:0]];
          if (seq_phase == SEQ_ARMED) begin
            if (cur.kind != SK_WRITE && cur.kind != SK_READ) begin
              if (edge_held) begin
                if (cur.kind == SK_WAIT) next_slot();
                else if (!rdy) end_job(ERR_DROPPED, 8'h00);
                else if (ack) next_slot();
                else if (cur.kind == SK_CHECK || !done) end_job(ERR_NACK, 8'h00);
                else begin
                  reason_pending = 1'b1;
                  begin_xfer(EV_REASON, REASON_OPCODE, '0, '0, REASON_LEN);
                end
              end else if (wait_ms >= cur.len) begin
                end_job(ERR_READY_TIMEOUT, 8'h00);
              end
            end else if (!done || !rdy) begin
              if (wait_ms >= lim_backend) end_job(!done ? ERR_BUSY : ERR_NOT_READY, 8'h00);
            end else begin
              begin_xfer((cur.kind == SK_WRITE) ? EV_WRITE : EV_READ, cur.opcode, cur.x,
                         cur.y, cur.len);
            end
          end else if (done) begin
            if (reason_pending) end_job(lerr ? ERR_NACK : ERR_NACK_CODE, it.opcode);
            else if (!lerr) next_slot();
            else end_job(ERR_XFER, 8'h00);
          end else if (wait_ms >= lim_xfer) begin
            was_query = reason_pending;
            post_word(EV_ABORT, '0, '0, '0, '0, ERR_OK, 8'h00);
            end_job(was_query ? ERR_NACK : ERR_XFER_TIMEOUT, 8'h00);
          end
          if (!(seq_phase == SEQ_ARMED && cur_step != prev)) break;
        end
      end
      default: ;
    endcase
    if (burst.size() != 0) burst[burst.size() - 1].last = 1'b1;
    while (burst.size() != 0) due_words.push_back(burst.pop_front());
  endtask

  function automatic int draw_gap();
    if ($urandom_range(0, 24) == 0) steady_run = !steady_run;
    return steady_run ? 0 : $urandom_range(0, 10);
  endfunction

  function automatic item_t rand_item(input logic [1:0] kind);
    item_t it;
    it.kind        = kind;
    it.slot        = 3'($urandom);
    it.step_kind   = 3'($urandom);
    it.opcode      = 8'($urandom);
    it.x           = 16'($urandom);
    it.y           = 16'($urandom);
    it.len         = 16'($urandom);
    it.tick        = 1'($urandom);
    it.ready_edge  = 1'($urandom);
    it.ready_level = 1'($urandom);
    it.ack_level   = 1'($urandom);
    it.link_state  = 2'($urandom);
    return it;
  endfunction

  function automatic string word_text(input result_t w);
    return $sformatf("ev=%0d op=%02h x=%04h y=%04h len=%04h err=%0d reason=%02h last=%0b",
                     w.event_res, w.opcode, w.x, w.y, w.len, w.err, w.nack_reason, w.last);
  endfunction

  task automatic queue_item(input item_t it);
    pending_items.push_back(it);
    if (it.kind != ITEM_UNUSED) queued_items++;
  endtask

  task automatic add_load(input logic [2:0] slot, input logic [2:0] sk,
                          input logic [7:0] op, input logic [15:0] x,
                          input logic [15:0] y, input logic [15:0] len);
    item_t it;
    it = rand_item(ITEM_LOAD);
    it.slot = slot;
    it.step_kind = sk;
    it.opcode = op;
    it.x = x;
    it.y = y;
    it.len = len;
    queue_item(it);
  endtask

  task automatic add_start(input logic [2:0] last_slot, input logic [15:0] cap);
    item_t it;
    it = rand_item(ITEM_START);
    it.slot = last_slot;
    it.len = cap;
    queue_item(it);
  endtask

  task automatic add_poll(input logic tick, input logic rdy_edge, input logic rdy,
                          input logic ack, input logic [1:0] link, input logic [7:0] status);
    item_t it;
    it = rand_item(ITEM_POLL);
    it.tick = tick;
    it.ready_edge = rdy_edge;
    it.ready_level = rdy;
    it.ack_level = ack;
    it.link_state = link;
    it.opcode = status;
    queue_item(it);
  endtask

  // Load a job, start it and feed it polls; a little noise mixed in
  task automatic queue_random_job();
    int          n;
    logic [2:0]  sk;
    logic [15:0] len, widest, cap;
    n = $urandom_range(1, SLOT_COUNT);
    widest = '0;
    for (int i = 0; i < n; i++) begin
      sk = ($urandom_range(0, 29) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      if ($urandom_range(0, 9) == 0) len = 16'($urandom);
      else if (sk == SK_WRITE || sk == SK_READ) len = 16'($urandom_range(0, 64));
      else len = 16'($urandom_range(0, 6));
      if ((sk == SK_WRITE || sk == SK_READ) && len > widest) widest = len;
      add_load(3'(i), sk, 8'($urandom), 16'($urandom), 16'($urandom), len);
    end
    if ($urandom_range(0, 7) == 0) cap = (widest != 0) ? widest - 16'd1 : 16'($urandom);
    else if (widest > 16'hFFEB) cap = 16'hFFFF;
    else cap = widest + 16'($urandom_range(0, 20));
    add_start(($urandom_range(0, 9) == 0) ? 3'($urandom) : 3'(n - 1), cap);
    repeat ($urandom_range(4, 24)) begin
      case ($urandom_range(0, 39))
        0: queue_item(rand_item(ITEM_UNUSED));
        1: queue_item(rand_item(ITEM_LOAD));
        2: queue_item(rand_item(ITEM_START));
        default: add_poll(1'($urandom), $urandom_range(0, 9) < 4, $urandom_range(0, 9) < 8,
                          $urandom_range(0, 9) < 7,
                          {$urandom_range(0, 9) < 2, $urandom_range(0, 9) < 7},
                          8'($urandom));
      endcase
    end
  endtask

  // Sampled on the falling edge so every update of the rising edge has settled
  task automatic wait_quiet();
    while (pending_items.size() != 0 || start || busy || due_words.size() != 0)
      @(negedge clk);
    repeat (QUIET_CYC) @(negedge clk);
  endtask

  always @(posedge clk) begin : item_driver
    logic hold;
    hold = start;
    if (!rst_n) begin
      hold = 1'b0;
    end else begin
      if (start && !busy) begin
        advance_sequencer(cur_item);
        hold = 1'b0;
        gap_left = draw_gap();
      end
      if (!hold) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (pending_items.size() != 0) begin
          cur_item = pending_items.pop_front();
          in_kind        <= cur_item.kind;
          in_slot        <= cur_item.slot;
          in_step_kind   <= cur_item.step_kind;
          in_opcode      <= cur_item.opcode;
          in_x           <= cur_item.x;
          in_y           <= cur_item.y;
          in_len         <= cur_item.len;
          in_tick        <= cur_item.tick;
          in_ready_edge  <= cur_item.ready_edge;
          in_ready_level <= cur_item.ready_level;
          in_ack_level   <= cur_item.ack_level;
          in_link_state  <= cur_item.link_state;
          hold = 1'b1;
        end
      end
    end
    start <= hold;
  end

  always @(posedge clk) begin : cfg_driver
    logic       hold;
    cfg_write_t w;
    hold = cfg_valid;
    if (!rst_n) begin
      hold = 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_BACKEND_WAIT) lim_backend = cfg_data;
        else if (cfg_index == REG_XFER_WAIT) lim_xfer = cfg_data;
        hold = 1'b0;
      end
      if (!hold && cfg_writes.size() != 0) begin
        w = cfg_writes.pop_front();
        cfg_index <= w.idx;
        cfg_data  <= w.data;
        hold = 1'b1;
      end
    end
    cfg_valid <= hold;
  end

  always @(posedge clk) begin : word_monitor
    result_t got, want;
    if (rst_n && out_valid) begin
      got.event_res   = out_event_res;
      got.opcode      = out_opcode_out;
      got.x           = out_x_out;
      got.y           = out_y_out;
      got.len         = out_len_out;
      got.err         = out_err;
      got.nack_reason = out_nack_reason;
      got.last        = out_last;
      if (due_words.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("%0t: unexpected word %s", $time, word_text(got));
      end else begin
        want = due_words.pop_front();
        if (got.event_res !== want.event_res || got.opcode !== want.opcode ||
            got.x !== want.x || got.y !== want.y || got.len !== want.len ||
            got.err !== want.err || got.nack_reason !== want.nack_reason ||
            got.last !== want.last) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: word mismatch\n  expected %s\n  actual   %s", $time,
                     word_text(want), word_text(got));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** link_job_step_sequencer_core: FAILED **");
      $finish;
    end
  end

  initial begin : stimulus
    logic [15:0] backend_set [PHASES];
    logic [15:0] xfer_set [PHASES];
    int          phase_target;
    backend_set = '{16'd0, 16'hFFFF, 16'd2, 16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0};
    xfer_set    = '{16'd0, 16'hFFFF, 16'd3, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0};
    for (int p = 5; p < PHASES; p++) begin
      backend_set[p] = 16'($urandom_range(0, 8));
      xfer_set[p]    = 16'($urandom_range(0, 8));
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // every slot gets loaded first, so no job ever reads an unwritten slot
    add_load(3'd0, SK_WRITE, 8'hFF, 16'hFFFF, 16'h0000, 16'd16);
    add_load(3'd1, SK_READ,  8'h00, 16'h0000, 16'hFFFF, 16'd8);
    add_load(3'd2, SK_WAIT,  8'h5A, 16'd1234, 16'd4321, 16'd3);
    add_load(3'd3, SK_CHECK, 8'hA5, 16'd7,    16'd9,    16'd2);
    add_load(3'd4, SK_QUERY, 8'h55, 16'd0,    16'd0,    16'd2);
    add_load(3'd5, SK_WRITE, 8'h80, 16'h8000, 16'h7FFF, 16'd0);
    add_load(3'd6, SK_BAD,   8'h11, 16'd1,    16'd2,    16'd3);
    add_load(3'd7, SK_READ,  8'h01, 16'd1,    16'd1,    16'hFFFF);
    add_start(3'd7, 16'hFFFF);                    // bad step kind in a used slot
    add_start(3'd5, 16'd10);                      // transfer longer than the buffer
    add_poll(1'b1, 1'b1, 1'b1, 1'b1, 2'b01, 8'h00); // idle poll, edge then cleared by start
    add_start(3'd5, 16'd16);
    add_load(3'd0, SK_READ, 8'h33, 16'd3, 16'd3, 16'd3); // refused while busy
    add_start(3'd0, 16'hFFFF);                    // refused while busy
    add_poll(1'b0, 1'b0, 1'b1, 1'b0, 2'b01, 8'h00);
    add_poll(1'b0, 1'b0, 1'b1, 1'b0, 2'b01, 8'h00);
    add_poll(1'b1, 1'b1, 1'b1, 1'b1, 2'b01, 8'h00); // one edge carries wait, check and query
    add_poll(1'b0, 1'b0, 1'b1, 1'b1, 2'b11, 8'h00); // transfer error
    add_load(3'd0, SK_QUERY, 8'h00, 16'd0, 16'd0, 16'd5);
    add_start(3'd0, 16'd0);
    add_poll(1'b0, 1'b1, 1'b1, 1'b0, 2'b01, 8'h00); // no ack: reason read starts
    add_poll(1'b0, 1'b0, 1'b0, 1'b0, 2'b01, 8'hC3);
    add_start(3'd0, 16'd0);
    add_poll(1'b1, 1'b1, 1'b0, 1'b0, 2'b00, 8'h00); // ready gone low on the edge
    queue_item(rand_item(ITEM_UNUSED));
    wait_quiet();

    for (int p = 0; p < PHASES; p++) begin
      cfg_writes.push_back('{idx: REG_BACKEND_WAIT, data: backend_set[p]});
      cfg_writes.push_back('{idx: REG_XFER_WAIT, data: xfer_set[p]});
      while (cfg_writes.size() != 0 || cfg_valid) @(negedge clk);
      phase_target = queued_items + PHASE_ITEMS;
      while (queued_items < phase_target) queue_random_job();
      wait_quiet();
    end

    fail_count += due_words.size();
    if (fail_count == 0) begin
      $display("** link_job_step_sequencer_core: PASSED **");
    end else begin
      $display("** link_job_step_sequencer_core: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/ljss_pkg.sv
hdl/ljss_ram.sv
hdl/ljss_cfg.sv
hdl/ljss_ctrl.sv
hdl/link_job_step_sequencer_core.sv
tb/sv/tb_link_job_step_sequencer_core.sv
